### hw/rtl/sui_pkg.sv
`default_nettype none

package sui_pkg;

  // Width of one tile id.
  localparam int unsigned IdW = 16;

  // Default capacity of the distinct-id store.
  localparam int unsigned MaxDistinctDef = 64;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CellHold,
    CellCompare,
    CellInsert,
    CellShift,
    CellCheck
  } cell_op_e;

  // Control that the sequencer sends to all cells.
  typedef struct packed {
    cell_op_e       op;
    logic [IdW-1:0] new_id;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic           valid;
    logic           lt;
    logic [IdW-1:0] id;
  } cell_data_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_unique_id_set.sv
`default_nettype none

// Collects the tile ids of one stamp into a sorted set of distinct ids held
// in a chain of MaxDistinct cells, and on the request marked last_cell emits
// every held id in ascending order, one result per id, each carrying its
// rank, the set size, a consecutive-run flag and an overflow flag. Each input
// request is accepted while idle; then every cell compares its id with the
// new one, and then the cells above the insertion point move up by one. A
// last-cell request then runs the consecutive check and its reduction, and
// the chain shifts down into the output one id at a time, each time a result
// is taken. A new id that finds the store full is dropped and raises
// overflowed. The set and the overflow flag clear after the final result,
// marked run_end, is taken.
module sorted_unique_id_set #(
  parameter int unsigned MaxDistinct = sui_pkg::MaxDistinctDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire [sui_pkg::IdW-1:0]   tile_id_i,
  input  wire                      last_cell_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic [sui_pkg::IdW-1:0]  sorted_id_o,
  output logic [5:0]               position_o,
  output logic                     run_end_o,
  output logic [6:0]               unique_count_o,
  output logic                     consecutive_o,
  output logic                     overflowed_o
);
  import sui_pkg::*;

  localparam int unsigned CntW = $clog2(MaxDistinct + 1);

  typedef enum logic [2:0] {
    StIdle,
    StCompare,
    StInsert,
    StCheck,
    StReduce,
    StEmit
  } state_e;

  state_e           state_q;
  logic [IdW-1:0]   id_q;
  logic             last_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  pos_q;
  logic             ovf_q;
  logic             consec_q;

  cell_ctrl_t                 ctrl;
  cell_data_t                 cell_data [MaxDistinct];
  logic [MaxDistinct-1:0]     eq_vec;
  logic [MaxDistinct-1:0]     consec_vec;
  logic                       dup;
  logic                       full;
  logic                       do_insert;
  logic                       run_end;
  logic                       out_take;

  assign dup       = |eq_vec;
  assign full      = (count_q == CntW'(MaxDistinct));
  assign do_insert = !dup && !full;
  assign run_end   = ((pos_q + {{(CntW-1){1'b0}}, 1'b1}) == count_q);
  assign out_take  = (state_q == StEmit) && !out_stall_i;

  // Operation broadcast to the chain.
  always_comb begin
    ctrl.new_id = id_q;
    ctrl.op     = CellHold;
    unique case (state_q)
      StIdle:    ctrl.op = CellHold;
      StCompare: ctrl.op = CellCompare;
      StInsert:  ctrl.op = do_insert ? CellInsert : CellHold;
      StCheck:   ctrl.op = CellCheck;
      StReduce:  ctrl.op = CellHold;
      StEmit:    ctrl.op = out_take ? CellShift : CellHold;
      default:   ctrl.op = CellHold;
    endcase
  end

  // The chain of cells; cell 0 holds the smallest id.
  for (genvar i = 0; i < MaxDistinct; i++) begin : g_cell
    cell_data_t left_d;
    cell_data_t right_d;

    if (i == 0) begin : g_first
      assign left_d = '{valid: 1'b1, lt: 1'b1, id: '0};
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end

    if (i == MaxDistinct - 1) begin : g_last
      assign right_d = '{valid: 1'b0, lt: 1'b0, id: '0};
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    sui_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .left_i   (left_d),
      .right_i  (right_d),
      .data_o   (cell_data[i]),
      .eq_o     (eq_vec[i]),
      .consec_o (consec_vec[i])
    );
  end

  // Sequencer state and set bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      last_q   <= 1'b0;
      count_q  <= '0;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
      consec_q <= 1'b1;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            last_q  <= last_cell_i;
            state_q <= StCompare;
          end
        end
        StCompare: begin
          state_q <= StInsert;
        end
        StInsert: begin
          if (do_insert) begin
            count_q <= count_q + {{(CntW-1){1'b0}}, 1'b1};
          end else if (!dup) begin
            ovf_q <= 1'b1;
          end
          state_q <= last_q ? StCheck : StIdle;
        end
        StCheck: begin
          state_q <= StReduce;
        end
        StReduce: begin
          consec_q <= &consec_vec;
          pos_q    <= '0;
          state_q  <= (count_q == '0) ? StIdle : StEmit;
        end
        StEmit: begin
          if (!out_stall_i) begin
            pos_q <= pos_q + {{(CntW-1){1'b0}}, 1'b1};
            if (run_end) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Captured tile id of the request in progress.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      id_q <= tile_id_i;
    end
  end

  // Result fields come straight from registers and cell 0.
  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = (state_q == StEmit);
  assign sorted_id_o    = cell_data[0].id;
  assign position_o     = 6'(pos_q);
  assign run_end_o      = run_end;
  assign unique_count_o = 7'(count_q);
  assign consecutive_o  = consec_q;
  assign overflowed_o   = ovf_q;

endmodule

`default_nettype wire

### hw/rtl/sui_cell.sv
`default_nettype none

module sui_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sui_pkg::cell_ctrl_t ctrl_i,
  input  sui_pkg::cell_data_t left_i,
  input  sui_pkg::cell_data_t right_i,
  output sui_pkg::cell_data_t data_o,
  output logic                eq_o,
  output logic                consec_o
);
  import sui_pkg::*;

  logic           valid_q, valid_d;
  logic [IdW-1:0] id_q, id_d;
  logic           lt_q, lt_d;
  logic           eq_q, eq_d;
  logic           consec_q, consec_d;
  logic [IdW:0]   id_inc;

  assign id_inc = {1'b0, id_q} + {{IdW{1'b0}}, 1'b1};

  // Next content of the cell for the broadcast operation.
  always_comb begin
    valid_d  = valid_q;
    id_d     = id_q;
    lt_d     = lt_q;
    eq_d     = eq_q;
    consec_d = consec_q;
    unique case (ctrl_i.op)
      CellHold: begin
      end
      CellCompare: begin
        lt_d = valid_q && (id_q < ctrl_i.new_id);
        eq_d = valid_q && (id_q == ctrl_i.new_id);
      end
      CellInsert: begin
        // Smaller ids stay; the insertion point takes the new id and the
        // cells above it take their left neighbor's content.
        if (!lt_q) begin
          if (left_i.lt) begin
            valid_d = 1'b1;
            id_d    = ctrl_i.new_id;
          end else begin
            valid_d = left_i.valid;
            id_d    = left_i.id;
          end
        end
        lt_d = 1'b0;
      end
      CellShift: begin
        valid_d = right_i.valid;
        id_d    = right_i.id;
      end
      CellCheck: begin
        consec_d = !right_i.valid || !valid_q || (id_inc == {1'b0, right_i.id});
      end
      default: begin
      end
    endcase
  end

  // Cell registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      lt_q     <= 1'b0;
      eq_q     <= 1'b0;
      consec_q <= 1'b1;
    end else begin
      valid_q  <= valid_d;
      lt_q     <= lt_d;
      eq_q     <= eq_d;
      consec_q <= consec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign data_o.valid = valid_q;
  assign data_o.lt    = lt_q;
  assign data_o.id    = id_q;
  assign eq_o         = eq_q;
  assign consec_o     = consec_q;

endmodule

`default_nettype wire
